// File: hw/rtl/lz77_sequence_block_decoder_macros.svh
// assertion macros for the lz77 sequence block decoder
`ifndef LZ77_SEQUENCE_BLOCK_DECODER_MACROS_SVH
`define LZ77_SEQUENCE_BLOCK_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define LZSBD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lzsbd assertion failed");
`define LZSBD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lzsbd implication failed");
`else
`define LZSBD_ASSERT(lbl, clk, rstn, prop)
`define LZSBD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/lzsbd_pkg.sv
// shared types and constants of the lz77 sequence block decoder
package lzsbd_pkg;

  localparam int CNT_W = 24;
  localparam int LEN_W = 26;
  localparam int SUM_W = 27;
  localparam logic [LEN_W-1:0] LEN_CAP = 26'h2000000;
  localparam logic [7:0] EXT_BYTE = 8'hFF;

  typedef enum logic [3:0] {
    PH_LEVEL, PH_TOKEN, PH_LITEXT, PH_LIT, PH_LASTLIT,
    PH_OFFSET, PH_MATCHEXT, PH_COPY, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_LEVEL    = 3'd1,
    ERR_OFFSET   = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_INPUT    = 3'd4,
    ERR_LASTLIT  = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    CMD_LIT, CMD_COPY, CMD_STAT
  } cmd_kind_e;

  typedef enum logic [1:0] {
    REG_OFFSET_BYTES, REG_INPUT_SIZE, REG_OUTPUT_LIMIT, REG_MAX_LEVEL
  } reg_idx_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       data;
    logic             done;
    err_e             err;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

// File: hw/rtl/lzsbd_if.sv
// request and response channel interfaces
interface lzsbd_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;
  modport source (output valid, req_type, in_byte, input ready);
  modport sink (input valid, req_type, in_byte, output ready);
endinterface

interface lzsbd_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_has_byte;
  logic        block_done;
  logic [2:0]  error_code;
  logic [23:0] produced_count;
  modport source (output valid, out_byte, out_has_byte, block_done, error_code,
                  produced_count, input ready);
  modport sink (input valid, out_byte, out_has_byte, block_done, error_code,
                produced_count, output ready);
endinterface

// File: hw/rtl/lz77_sequence_block_decoder.sv
// top level of the lz77 sequence block decoder
// Decodes one compressed block per reset. The request channel carries either a
// compressed byte (req_type 0) or a copy tick (req_type 1) that yields one byte
// of a pending match. The response channel returns decoded bytes and one final
// item with block_done set and the error code.
// Registers are written over the cfg port: 0 offset width, 1 input size,
// 2 output limit, 3 maximum level byte.
// Throughput: one request per cycle while the command queue has space. The front
// parses each byte in the cycle it is taken; the back reads and writes the history
// memory once per cycle while not stalled, forwarding the byte just written when a
// copy has offset one. A result passes through the command queue, the memory read
// stage and the output register.
// Reset clears all control state; the history memory is not cleared, since a copy
// never reads an entry that was not written in this block.
// When the receiver stalls, the output register, the execute stage and the
// two-entry queue fill, and then request ready drops until space frees up.
module lz77_sequence_block_decoder #(
  parameter int WINDOW_LOG    = 16,
  parameter int LEN_BITS      = 4,
  parameter int MIN_MATCH     = 4,
  parameter int LAST_LITERALS = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_wdata_i,
  lzsbd_req_if.sink    req_if,
  lzsbd_rsp_if.source  rsp_if
);

  localparam int CMD_W = $bits(lzsbd_pkg::cmd_t);
  localparam int QW = CMD_W + 2 * WINDOW_LOG;

  logic                  push, space, q_vld, pop;
  lzsbd_pkg::cmd_t       f_cmd, b_cmd;
  logic [WINDOW_LOG-1:0] f_rd, f_wr, b_rd, b_wr;
  logic [QW-1:0]         q_out;

  lzsbd_front #(
    .WINDOW_LOG    (WINDOW_LOG),
    .LEN_BITS      (LEN_BITS),
    .MIN_MATCH     (MIN_MATCH),
    .LAST_LITERALS (LAST_LITERALS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (req_if.ready),
    .in_type_i   (req_if.req_type),
    .in_byte_i   (req_if.in_byte),
    .space_i     (space),
    .push_o      (push),
    .cmd_o       (f_cmd),
    .rd_addr_o   (f_rd),
    .wr_addr_o   (f_wr)
  );

  lzsbd_queue #(
    .W (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_cmd, f_rd, f_wr}),
    .space_o (space),
    .vld_o   (q_vld),
    .pop_i   (pop),
    .data_o  (q_out)
  );

  assign b_cmd = lzsbd_pkg::cmd_t'(q_out[QW-1 -: CMD_W]);
  assign b_rd  = q_out[2*WINDOW_LOG-1 -: WINDOW_LOG];
  assign b_wr  = q_out[WINDOW_LOG-1:0];

  lzsbd_back #(
    .WINDOW_LOG (WINDOW_LOG)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_vld_i          (q_vld),
    .pop_o            (pop),
    .cmd_i            (b_cmd),
    .rd_addr_i        (b_rd),
    .wr_addr_i        (b_wr),
    .out_valid_o      (rsp_if.valid),
    .out_ready_i      (rsp_if.ready),
    .out_byte_o       (rsp_if.out_byte),
    .out_has_byte_o   (rsp_if.out_has_byte),
    .block_done_o     (rsp_if.block_done),
    .error_code_o     (rsp_if.error_code),
    .produced_count_o (rsp_if.produced_count)
  );

endmodule

// File: hw/rtl/lzsbd_queue.sv
// two-entry command queue between front and back
module lzsbd_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         space_o,
  output logic         vld_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] ent_q [2];
  logic         wp_q, wp_d, rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;

  assign space_o = (cnt_q != 2'd2);
  assign vld_o   = (cnt_q != 2'd0);
  assign data_o  = ent_q[rp_q];

  // pointer and fill count
  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/lzsbd_front.sv
// front: parses the compressed stream and issues commands to the back
module lzsbd_front #(
  parameter int WINDOW_LOG    = 16,
  parameter int LEN_BITS      = 4,
  parameter int MIN_MATCH     = 4,
  parameter int LAST_LITERALS = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [23:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_type_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  space_i,
  output logic                  push_o,
  output lzsbd_pkg::cmd_t       cmd_o,
  output logic [WINDOW_LOG-1:0] rd_addr_o,
  output logic [WINDOW_LOG-1:0] wr_addr_o
);

  localparam int LL_W = 8 - LEN_BITS;
  localparam int CW = lzsbd_pkg::CNT_W;
  localparam int LW = lzsbd_pkg::LEN_W;
  localparam int SW = lzsbd_pkg::SUM_W;
  localparam logic [LL_W-1:0] LL_MASK = {LL_W{1'b1}};
  localparam logic [LEN_BITS-1:0] ML_MASK = {LEN_BITS{1'b1}};
  localparam logic [24:0] HIST_SIZE = 25'(1) << WINDOW_LOG;

  // configuration registers
  logic [1:0]  off_bytes_q;
  logic [23:0] in_size_q, out_limit_q;
  logic [7:0]  max_level_q;

  // decode state
  lzsbd_pkg::phase_e   phase_q, phase_d;
  logic [LW-1:0]       lit_rem_q, lit_rem_d, match_rem_q, match_rem_d;
  logic [23:0]         off_q, off_d;
  logic [1:0]          off_idx_q, off_idx_d;
  logic [LEN_BITS-1:0] nib_q, nib_d;
  logic [CW-1:0]       cons_q, cons_d, wr_q, wr_d;

  logic          accept;
  logic [1:0]    ow;
  logic [CW-1:0] cons_n;
  logic [LW-1:0] lit_sat, match_sat, lld_len, mld_len;
  logic [SW-1:0] lit_sum, match_sum, endp, wlen, mlen_chk;
  logic [23:0]   acc;
  logic [1:0]    idx_n;
  logic          ended, has;

  assign accept     = in_valid_i && space_i;
  assign in_ready_o = space_i;
  assign ow         = (off_bytes_q == 2'd3) ? 2'd3 : 2'd2;
  assign cons_n     = cons_q + CW'(1);

  // saturating length accumulation
  always_comb begin
    lit_sum   = SW'(lit_rem_q) + SW'(in_byte_i);
    match_sum = SW'(match_rem_q) + SW'(in_byte_i);
    lit_sat   = (lit_sum > SW'(lzsbd_pkg::LEN_CAP)) ? lzsbd_pkg::LEN_CAP : lit_sum[LW-1:0];
    match_sat = (match_sum > SW'(lzsbd_pkg::LEN_CAP)) ? lzsbd_pkg::LEN_CAP
                                                       : match_sum[LW-1:0];
  end

  // literal and match length checks
  always_comb begin
    lld_len  = (phase_q == lzsbd_pkg::PH_TOKEN) ? LW'(in_byte_i[7:LEN_BITS]) : lit_sat;
    mld_len  = (phase_q == lzsbd_pkg::PH_OFFSET) ? (LW'(nib_q) + LW'(MIN_MATCH))
                                                 : (match_sat + LW'(MIN_MATCH));
    endp     = SW'(cons_n) + SW'(lld_len);
    wlen     = SW'(wr_q) + SW'(lld_len);
    mlen_chk = SW'(wr_q) + SW'(mld_len) + SW'(LAST_LITERALS);
  end

  // offset byte assembly
  always_comb begin
    case (off_idx_q)
      2'd0:    acc = off_q | {16'd0, in_byte_i};
      2'd1:    acc = off_q | {8'd0, in_byte_i, 8'd0};
      2'd2:    acc = off_q | {in_byte_i, 16'd0};
      default: acc = off_q;
    endcase
    idx_n = off_idx_q + 2'd1;
  end

  // next state and command
  always_comb begin
    phase_d     = phase_q;
    lit_rem_d   = lit_rem_q;
    match_rem_d = match_rem_q;
    off_d       = off_q;
    off_idx_d   = off_idx_q;
    nib_d       = nib_q;
    cons_d      = cons_q;
    wr_d        = wr_q;
    push_o      = 1'b0;
    ended       = 1'b0;
    has         = 1'b0;
    cmd_o       = '{kind: lzsbd_pkg::CMD_STAT, data: 8'd0, done: 1'b0,
                    err: lzsbd_pkg::ERR_OK, count: wr_q};
    rd_addr_o   = WINDOW_LOG'(wr_q - off_q);
    wr_addr_o   = WINDOW_LOG'(wr_q);

    if (accept && phase_q != lzsbd_pkg::PH_DONE) begin
      if (in_type_i) begin
        if (phase_q == lzsbd_pkg::PH_COPY) begin
          wr_d        = wr_q + CW'(1);
          match_rem_d = match_rem_q - LW'(1);
          if (match_rem_d == '0) begin
            phase_d = lzsbd_pkg::PH_TOKEN;
          end
          push_o     = 1'b1;
          cmd_o.kind = lzsbd_pkg::CMD_COPY;
        end
      end else if (phase_q != lzsbd_pkg::PH_COPY) begin
        cons_d = cons_n;
        unique case (phase_q)
          lzsbd_pkg::PH_LEVEL: begin
            if (out_limit_q == '0) begin
              ended     = 1'b1;
              cmd_o.err = (in_size_q == 24'd1 && in_byte_i == 8'd0) ? lzsbd_pkg::ERR_OK
                                                                    : lzsbd_pkg::ERR_OVERFLOW;
            end else if (in_byte_i == 8'd0 || in_byte_i > max_level_q) begin
              ended     = 1'b1;
              cmd_o.err = lzsbd_pkg::ERR_LEVEL;
            end else begin
              phase_d = lzsbd_pkg::PH_TOKEN;
            end
          end
          lzsbd_pkg::PH_TOKEN, lzsbd_pkg::PH_LITEXT: begin
            lit_rem_d = lld_len;
            if (phase_q == lzsbd_pkg::PH_TOKEN) begin
              nib_d = in_byte_i[LEN_BITS-1:0];
            end
            if (phase_q == lzsbd_pkg::PH_TOKEN && in_byte_i[7:LEN_BITS] == LL_MASK) begin
              phase_d = lzsbd_pkg::PH_LITEXT;
            end else if (phase_q == lzsbd_pkg::PH_LITEXT &&
                         in_byte_i == lzsbd_pkg::EXT_BYTE) begin
              phase_d = lzsbd_pkg::PH_LITEXT;
            end else if (endp == SW'(in_size_q)) begin
              if (wlen > SW'(out_limit_q)) begin
                ended     = 1'b1;
                cmd_o.err = lzsbd_pkg::ERR_OVERFLOW;
              end else if (lld_len == '0) begin
                ended = 1'b1;
              end else begin
                phase_d = lzsbd_pkg::PH_LASTLIT;
              end
            end else if (endp > SW'(in_size_q) ||
                         endp + SW'(ow) + SW'(1) + SW'(LAST_LITERALS) > SW'(in_size_q)) begin
              ended     = 1'b1;
              cmd_o.err = lzsbd_pkg::ERR_INPUT;
            end else if (wlen > SW'(out_limit_q)) begin
              ended     = 1'b1;
              cmd_o.err = lzsbd_pkg::ERR_OVERFLOW;
            end else begin
              off_d     = '0;
              off_idx_d = '0;
              phase_d   = (lld_len != '0) ? lzsbd_pkg::PH_LIT : lzsbd_pkg::PH_OFFSET;
            end
          end
          lzsbd_pkg::PH_LIT, lzsbd_pkg::PH_LASTLIT: begin
            wr_d      = wr_q + CW'(1);
            lit_rem_d = lit_rem_q - LW'(1);
            has       = 1'b1;
            if (lit_rem_d == '0) begin
              if (phase_q == lzsbd_pkg::PH_LASTLIT) begin
                phase_d     = lzsbd_pkg::PH_DONE;
                push_o      = 1'b1;
                cmd_o.kind  = lzsbd_pkg::CMD_LIT;
                cmd_o.data  = in_byte_i;
                cmd_o.done  = 1'b1;
                cmd_o.count = wr_d;
                has         = 1'b0;
              end else begin
                off_d     = '0;
                off_idx_d = '0;
                phase_d   = lzsbd_pkg::PH_OFFSET;
              end
            end
          end
          lzsbd_pkg::PH_OFFSET: begin
            off_d     = acc;
            off_idx_d = idx_n;
            if (idx_n >= ow) begin
              if (acc == '0 || acc > wr_q || {1'b0, acc} > HIST_SIZE) begin
                ended     = 1'b1;
                cmd_o.err = lzsbd_pkg::ERR_OFFSET;
              end else if (nib_q == ML_MASK) begin
                match_rem_d = LW'(nib_q);
                phase_d     = lzsbd_pkg::PH_MATCHEXT;
              end else if (mlen_chk > SW'(out_limit_q)) begin
                ended     = 1'b1;
                cmd_o.err = lzsbd_pkg::ERR_LASTLIT;
              end else begin
                match_rem_d = mld_len;
                phase_d     = lzsbd_pkg::PH_COPY;
              end
            end
          end
          lzsbd_pkg::PH_MATCHEXT: begin
            match_rem_d = match_sat;
            if (SW'(cons_n) + SW'(LAST_LITERALS) > SW'(in_size_q)) begin
              ended     = 1'b1;
              cmd_o.err = lzsbd_pkg::ERR_INPUT;
            end else if (in_byte_i != lzsbd_pkg::EXT_BYTE) begin
              if (mlen_chk > SW'(out_limit_q)) begin
                ended     = 1'b1;
                cmd_o.err = lzsbd_pkg::ERR_LASTLIT;
              end else begin
                match_rem_d = mld_len;
                phase_d     = lzsbd_pkg::PH_COPY;
              end
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase

        // block end by error, early success or exhausted input
        if (ended) begin
          phase_d    = lzsbd_pkg::PH_DONE;
          push_o     = 1'b1;
          cmd_o.done = 1'b1;
        end else if (phase_d != lzsbd_pkg::PH_DONE && cons_n >= in_size_q) begin
          phase_d     = lzsbd_pkg::PH_DONE;
          push_o      = 1'b1;
          cmd_o.done  = 1'b1;
          cmd_o.err   = lzsbd_pkg::ERR_INPUT;
          cmd_o.kind  = has ? lzsbd_pkg::CMD_LIT : lzsbd_pkg::CMD_STAT;
          cmd_o.data  = has ? in_byte_i : 8'd0;
          cmd_o.count = wr_d;
        end else if (has) begin
          push_o      = 1'b1;
          cmd_o.kind  = lzsbd_pkg::CMD_LIT;
          cmd_o.data  = in_byte_i;
          cmd_o.count = wr_d;
        end
      end
      if (in_type_i && phase_q == lzsbd_pkg::PH_COPY) begin
        cmd_o.count = wr_d;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_bytes_q <= 2'd2;
      in_size_q   <= 24'd1;
      out_limit_q <= 24'd0;
      max_level_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (lzsbd_pkg::reg_idx_e'(cfg_idx_i))
        lzsbd_pkg::REG_OFFSET_BYTES: off_bytes_q <= cfg_wdata_i[1:0];
        lzsbd_pkg::REG_INPUT_SIZE:   in_size_q   <= cfg_wdata_i;
        lzsbd_pkg::REG_OUTPUT_LIMIT: out_limit_q <= cfg_wdata_i;
        lzsbd_pkg::REG_MAX_LEVEL:    max_level_q <= cfg_wdata_i[7:0];
        default:                     max_level_q <= max_level_q;
      endcase
    end
  end

  // decode state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lzsbd_pkg::PH_LEVEL;
      lit_rem_q   <= '0;
      match_rem_q <= '0;
      off_q       <= '0;
      off_idx_q   <= '0;
      nib_q       <= '0;
      cons_q      <= '0;
      wr_q        <= '0;
    end else begin
      phase_q     <= phase_d;
      lit_rem_q   <= lit_rem_d;
      match_rem_q <= match_rem_d;
      off_q       <= off_d;
      off_idx_q   <= off_idx_d;
      nib_q       <= nib_d;
      cons_q      <= cons_d;
      wr_q        <= wr_d;
    end
  end

endmodule

// File: hw/rtl/lzsbd_back.sv
// back: history memory, copy forwarding and output register
`include "lz77_sequence_block_decoder_macros.svh"
module lzsbd_back #(
  parameter int WINDOW_LOG = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_vld_i,
  output logic                  pop_o,
  input  lzsbd_pkg::cmd_t       cmd_i,
  input  logic [WINDOW_LOG-1:0] rd_addr_i,
  input  logic [WINDOW_LOG-1:0] wr_addr_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_has_byte_o,
  output logic                  block_done_o,
  output logic [2:0]            error_code_o,
  output logic [23:0]           produced_count_o
);

  localparam int DEPTH = 1 << WINDOW_LOG;

  logic [7:0] hist_mem [DEPTH];
  logic [7:0] rdata_q;

  // execute stage
  logic                  b_vld_q, b_vld_d;
  lzsbd_pkg::cmd_t       b_cmd_q;
  logic [WINDOW_LOG-1:0] b_wr_q;
  logic                  byp_q, byp_d;
  logic [7:0]            byp_data_q;
  logic                  b_adv, b_we, b_has;
  logic [7:0]            b_wdata;

  // output register
  logic        o_vld_q, o_vld_d;
  logic [7:0]  o_byte_q;
  logic        o_has_q, o_done_q;
  logic [2:0]  o_err_q;
  logic [23:0] o_cnt_q;

  // stage handshakes and write data
  always_comb begin
    b_adv   = !o_vld_q || out_ready_i;
    pop_o   = q_vld_i && (!b_vld_q || b_adv);
    b_has   = (b_cmd_q.kind != lzsbd_pkg::CMD_STAT);
    b_we    = b_vld_q && b_adv && b_has;
    b_wdata = (b_cmd_q.kind == lzsbd_pkg::CMD_LIT) ? b_cmd_q.data
            : (byp_q ? byp_data_q : rdata_q);
    byp_d   = b_we && (rd_addr_i == b_wr_q);
    b_vld_d = pop_o || (b_vld_q && !b_adv);
    o_vld_d = b_adv ? b_vld_q : 1'b0;
    if (!b_adv) begin
      o_vld_d = o_vld_q;
    end
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      hist_mem[b_wr_q] <= b_wdata;
    end
    if (pop_o) begin
      rdata_q <= hist_mem[rd_addr_i];
    end
  end

  // execute stage payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_cmd_q    <= cmd_i;
      b_wr_q     <= wr_addr_i;
      byp_data_q <= b_wdata;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      o_byte_q <= b_has ? b_wdata : 8'd0;
      o_has_q  <= b_has;
      o_done_q <= b_cmd_q.done;
      o_err_q  <= b_cmd_q.err;
      o_cnt_q  <= b_cmd_q.count;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      byp_q   <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      b_vld_q <= b_vld_d;
      if (pop_o) begin
        byp_q <= byp_d;
      end
      o_vld_q <= o_vld_d;
    end
  end

  assign out_valid_o      = o_vld_q;
  assign out_byte_o       = o_byte_q;
  assign out_has_byte_o   = o_has_q;
  assign block_done_o     = o_done_q;
  assign error_code_o     = o_err_q;
  assign produced_count_o = o_cnt_q;

  `LZSBD_ASSERT_IMPL(a_err_ends, clk_i, rst_ni,
                     o_vld_q && o_err_q != lzsbd_pkg::ERR_OK, o_done_q)
  `LZSBD_ASSERT_IMPL(a_result_has_byte, clk_i, rst_ni, o_vld_q && !o_done_q, o_has_q)
  `LZSBD_ASSERT(a_pop_needs_room, clk_i, rst_ni, !(pop_o && b_vld_q && !b_adv))

endmodule

// File: dv/lzsbd_checker.sv
// predictor and scoreboard for the lz77 sequence block decoder
module lzsbd_checker
  import lzsbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  lzsbd_req_if        req_if,
  lzsbd_rsp_if        rsp_if,
  output int          fail_count,
  output int          waiting_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_LOG    = 16;
  localparam int LEN_BITS      = 4;
  localparam int MIN_MATCH     = 4;
  localparam int LAST_LITERALS = 5;
  localparam longint HIST_DEPTH = 64'd1 << WINDOW_LOG;
  localparam logic [3:0] ML_ALL = 4'((1 << LEN_BITS) - 1);
  localparam logic [7:0] LL_ALL = 8'((1 << (8 - LEN_BITS)) - 1);

  typedef struct {
    logic [7:0]       data;
    logic             has;
    logic             done;
    err_e             err;
    logic [CNT_W-1:0] count;
  } dec_rsp_t;

  dec_rsp_t expected_q[$];

  // register copies
  logic [1:0]       offset_sel;
  logic [CNT_W-1:0] in_size;
  logic [CNT_W-1:0] out_limit;
  logic [7:0]       level_max;

  // decoder state
  phase_e           phase;
  logic [LEN_W-1:0] lit_left;
  logic [LEN_W-1:0] match_left;
  logic [CNT_W-1:0] offset_acc;
  logic [1:0]       offset_idx;
  logic [3:0]       match_nibble;
  logic [CNT_W-1:0] consumed;
  logic [CNT_W-1:0] written;
  logic [7:0]       history [HIST_DEPTH];

  function automatic longint offset_width();
    return (offset_sel == 2'd3) ? 3 : 2;
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(longint s);
    return (s > longint'(LEN_CAP)) ? LEN_CAP : LEN_W'(s);
  endfunction

  task automatic push_rsp(logic [7:0] d, logic h, logic dn, err_e e);
    dec_rsp_t r;
    r.data = d;
    r.has = h;
    r.done = dn;
    r.err = e;
    r.count = written;
    expected_q.push_back(r);
  endtask

  task automatic end_block(err_e e);
    phase = PH_DONE;
    push_rsp(8'd0, 1'b0, 1'b1, e);
  endtask

  // literal length known: last sequence or limit checks
  task automatic literal_length_known(output bit ended);
    longint p, len, w, insz, olim;
    p = longint'(consumed);
    len = longint'(lit_left);
    w = longint'(written);
    insz = longint'(in_size);
    olim = longint'(out_limit);
    ended = 1'b1;
    if (p + len == insz) begin
      if (w + len > olim) end_block(ERR_OVERFLOW);
      else if (len == 0) end_block(ERR_OK);
      else begin
        phase = PH_LASTLIT;
        ended = 1'b0;
      end
    end else if (p + len > insz) begin
      end_block(ERR_INPUT);
    end else if (p + len + offset_width() + 1 + LAST_LITERALS > insz) begin
      end_block(ERR_INPUT);
    end else if (w + len > olim) begin
      end_block(ERR_OVERFLOW);
    end else begin
      offset_acc = '0;
      offset_idx = '0;
      phase = (len != 0) ? PH_LIT : PH_OFFSET;
      ended = 1'b0;
    end
  endtask

  // match length known: add the minimum and check the tail margin
  task automatic match_length_known(output bit ended);
    longint len;
    len = longint'(match_left) + MIN_MATCH;
    ended = 1'b1;
    if (longint'(written) + len + LAST_LITERALS > longint'(out_limit)) begin
      end_block(ERR_LASTLIT);
    end else begin
      match_left = LEN_W'(len);
      phase = PH_COPY;
      ended = 1'b0;
    end
  endtask

  // one accepted request item
  task automatic decode_item(logic typ, logic [7:0] b);
    logic [7:0] v;
    logic       has;
    bit         ended;
    has = 1'b0;
    ended = 1'b0;
    if (phase == PH_DONE) return;
    if (typ) begin
      if (phase != PH_COPY) return;
      v = history[(written - offset_acc) & (HIST_DEPTH - 1)];
      history[written & (HIST_DEPTH - 1)] = v;
      written++;
      match_left--;
      if (match_left == 0) phase = PH_TOKEN;
      push_rsp(v, 1'b1, 1'b0, ERR_OK);
      return;
    end
    if (phase == PH_COPY) return;
    consumed++;
    case (phase)
      PH_LEVEL: begin
        if (out_limit == 0) begin
          end_block((in_size == 1 && b == 0) ? ERR_OK : ERR_OVERFLOW);
          return;
        end
        if (b == 0 || b > level_max) begin
          end_block(ERR_LEVEL);
          return;
        end
        phase = PH_TOKEN;
      end
      PH_TOKEN: begin
        match_nibble = b[LEN_BITS-1:0];
        lit_left = LEN_W'(b >> LEN_BITS);
        if (lit_left == LL_ALL) phase = PH_LITEXT;
        else begin
          literal_length_known(ended);
          if (ended) return;
        end
      end
      PH_LITEXT: begin
        lit_left = sat_len(longint'(lit_left) + longint'(b));
        if (b != EXT_BYTE) begin
          literal_length_known(ended);
          if (ended) return;
        end
      end
      PH_LIT, PH_LASTLIT: begin
        history[written & (HIST_DEPTH - 1)] = b;
        written++;
        lit_left--;
        has = 1'b1;
        if (lit_left == 0) begin
          if (phase == PH_LASTLIT) begin
            phase = PH_DONE;
            push_rsp(b, 1'b1, 1'b1, ERR_OK);
            return;
          end
          offset_acc = '0;
          offset_idx = '0;
          phase = PH_OFFSET;
        end
      end
      PH_OFFSET: begin
        offset_acc = offset_acc | (CNT_W'(b) << (8 * offset_idx));
        offset_idx++;
        if (offset_idx >= offset_width()) begin
          if (offset_acc == 0 || offset_acc > written || offset_acc > HIST_DEPTH) begin
            end_block(ERR_OFFSET);
            return;
          end
          match_left = LEN_W'(match_nibble);
          if (match_nibble == ML_ALL) phase = PH_MATCHEXT;
          else begin
            match_length_known(ended);
            if (ended) return;
          end
        end
      end
      PH_MATCHEXT: begin
        match_left = sat_len(longint'(match_left) + longint'(b));
        if (longint'(consumed) + LAST_LITERALS > longint'(in_size)) begin
          end_block(ERR_INPUT);
          return;
        end
        if (b != EXT_BYTE) begin
          match_length_known(ended);
          if (ended) return;
        end
      end
      default: ;
    endcase
    // input used up before the block completed
    if (phase != PH_DONE && consumed >= in_size) begin
      phase = PH_DONE;
      push_rsp(has ? b : 8'd0, has, 1'b1, ERR_INPUT);
    end else if (has) begin
      push_rsp(b, 1'b1, 1'b0, ERR_OK);
    end
  endtask

  // compare one response item against the oldest expectation
  task automatic check_rsp();
    dec_rsp_t e;
    result_count++;
    if (expected_q.size() == 0) begin
      $error("unexpected response item: byte %0h done %0b", rsp_if.out_byte,
             rsp_if.block_done);
      fail_count++;
      return;
    end
    e = expected_q.pop_front();
    if (rsp_if.out_byte !== e.data) begin
      $error("out_byte: expected %0h actual %0h", e.data, rsp_if.out_byte);
      fail_count++;
    end
    if (rsp_if.out_has_byte !== e.has) begin
      $error("out_has_byte: expected %0b actual %0b", e.has, rsp_if.out_has_byte);
      fail_count++;
    end
    if (rsp_if.block_done !== e.done) begin
      $error("block_done: expected %0b actual %0b", e.done, rsp_if.block_done);
      fail_count++;
    end
    if (rsp_if.error_code !== e.err) begin
      $error("error_code: expected %0d actual %0d", e.err, rsp_if.error_code);
      fail_count++;
    end
    if (rsp_if.produced_count !== e.count) begin
      $error("produced_count: expected %0d actual %0d", e.count, rsp_if.produced_count);
      fail_count++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_sel <= 2'd2;
      in_size <= 24'd1;
      out_limit <= 24'd0;
      level_max <= 8'd255;
      phase <= PH_LEVEL;
      lit_left <= '0;
      match_left <= '0;
      offset_acc <= '0;
      offset_idx <= '0;
      match_nibble <= '0;
      consumed <= '0;
      written <= '0;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OFFSET_BYTES: offset_sel = cfg_wdata_i[1:0];
          REG_INPUT_SIZE:   in_size = cfg_wdata_i;
          REG_OUTPUT_LIMIT: out_limit = cfg_wdata_i;
          REG_MAX_LEVEL:    level_max = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) decode_item(req_if.req_type, req_if.in_byte);
      if (rsp_if.valid && rsp_if.ready) check_rsp();
    end
  end

  assign waiting_count = expected_q.size();

endmodule

// File: dv/tb_top.sv
// top of the lz77 sequence block decoder testbench: stimulus and verdict
module tb_top;
  import lzsbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1950;
  localparam int IDLE_LIMIT  = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_wdata_i;

  lzsbd_req_if req_if ();
  lzsbd_rsp_if rsp_if ();

  int  fail_count, waiting_count, result_count;
  int  items_sent, seq_count, idle_cycles;
  int  out_total, in_total, off_width;
  bit  calm;

  lz77_sequence_block_decoder uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .req_if(req_if), .rsp_if(rsp_if)
  );

  lzsbd_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .req_if(req_if), .rsp_if(rsp_if),
    .fail_count(fail_count), .waiting_count(waiting_count), .result_count(result_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // send one request item, after a random gap unless calm
  task automatic put(logic typ, logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= typ;
    req_if.in_byte <= b;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // a compressed byte the decoder will take
  task automatic put_byte(logic [7:0] b);
    put(1'b0, b);
    in_total++;
    items_sent++;
    if (items_sent % 120 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  // length extension bytes for a value past the all-ones field
  task automatic put_ext(int rest);
    while (rest >= 255) begin
      put_byte(8'hFF);
      rest -= 255;
    end
    put_byte(rest[7:0]);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [23:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // let the decoder drain before a register write
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (waiting_count != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // one sequence with literals and a match
  task automatic send_sequence(bit directed_edge);
    int lits, mlen, mext, max_off, offset_val, ticks;
    logic [3:0] nib;
    if (out_total == 0) lits = $urandom_range(1, 20);
    else if ($urandom_range(0, 9) == 0) lits = $urandom_range(15, 300);
    else lits = $urandom_range(0, 14);
    nib = 4'($urandom_range(0, 15));
    if (directed_edge) begin
      lits = 15;
      nib = 4'hF;
    end
    mext = (nib == 4'hF) ? (($urandom_range(0, 7) == 0) ? $urandom_range(255, 400)
                                                         : $urandom_range(0, 30)) : 0;
    // stray copy tick at a token boundary is dropped
    if ($urandom_range(0, 19) == 0) put(1'b1, 8'($urandom));
    put_byte({(lits >= 15) ? 4'hF : 4'(lits), nib});
    if (lits >= 15) put_ext(lits - 15);
    repeat (lits) put_byte(8'($urandom));
    out_total += lits;
    max_off = (out_total < 65536) ? out_total : 65536;
    if (off_width == 2 && max_off > 65535) max_off = 65535;
    case ($urandom_range(0, 5))
      0: offset_val = 1;
      1: offset_val = max_off;
      default: offset_val = $urandom_range(1, (max_off < 40) ? max_off : 40);
    endcase
    put_byte(offset_val[7:0]);
    put_byte(offset_val[15:8]);
    if (off_width == 3) put_byte(offset_val[23:16]);
    if (nib == 4'hF) put_ext(mext);
    mlen = nib + mext + 4;
    ticks = 0;
    while (ticks < mlen) begin
      // stray compressed byte during a copy is dropped
      if ($urandom_range(0, 19) == 0) put(1'b0, 8'($urandom));
      put(1'b1, 8'($urandom));
      items_sent++;
      ticks++;
    end
    out_total += mlen;
    seq_count++;
  endtask

  // response ready with random stalls
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int lvl_max, last_lits, sel;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 2'd0;
    cfg_wdata_i = 24'd0;
    req_if.valid = 1'b0;
    req_if.req_type = 1'b0;
    req_if.in_byte = 8'd0;
    idle_cycles = 0;
    items_sent = 0;
    seq_count = 0;
    out_total = 0;
    in_total = 0;
    calm = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // block setup with wide offsets and the largest limits
    off_width = 3;
    lvl_max = $urandom_range(1, 255);
    write_reg(REG_OFFSET_BYTES, 24'd3);
    write_reg(REG_INPUT_SIZE, 24'hFFFFFF);
    write_reg(REG_OUTPUT_LIMIT, 24'hFFFFFF);
    write_reg(REG_MAX_LEVEL, 24'(lvl_max));
    put_byte(8'(lvl_max));

    // directed: all-ones length fields with extensions, then plain sequences
    send_sequence(1'b1);
    send_sequence(1'b0);

    while (items_sent < ITEM_TARGET) begin
      if (seq_count % 8 == 0) begin
        settle();
        sel = $urandom_range(0, 3);
        off_width = (sel == 3) ? 3 : 2;
        write_reg(REG_OFFSET_BYTES, 24'(sel));
        write_reg(REG_MAX_LEVEL, ($urandom_range(0, 1) == 0) ? 24'd1 : 24'd255);
        write_reg(REG_OUTPUT_LIMIT, 24'hFFFFFF - 24'($urandom_range(0, 1000)));
      end
      send_sequence(1'b0);
    end

    // last sequence ends exactly at the input size and the output limit
    settle();
    last_lits = $urandom_range(1, 30);
    write_reg(REG_INPUT_SIZE, 24'(in_total + 1 + (last_lits >= 15) + last_lits));
    write_reg(REG_OUTPUT_LIMIT, 24'(out_total + last_lits));
    put_byte({(last_lits >= 15) ? 4'hF : 4'(last_lits), 4'($urandom)});
    if (last_lits >= 15) put_byte(8'(last_lits - 15));
    repeat (last_lits) put_byte(8'($urandom));
    out_total += last_lits;

    // requests after the block ends are dropped
    repeat (5) put(1'($urandom), 8'($urandom));
    req_if.valid <= 1'b0;

    while (waiting_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("run covered %0d request items in %0d sequences, %0d decoded bytes",
             items_sent, seq_count + 1, out_total);
    $display("response items checked: %0d", result_count);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
